// ===== rtl/spt_pkg.sv =====
// Shared types, constants and microcode ROM for the semiprime tester.
// Depends on nothing; every other file uses it by scoped names.
package spt_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int STEP_W      = 4;
  localparam int ACT_W       = 3;
  localparam int COND_W      = 4;

  // datapath actions
  localparam logic [ACT_W-1:0] ACT_NONE      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD      = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SET_D     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DIV_GO    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_D_INC     = 3'd4;
  localparam logic [ACT_W-1:0] ACT_NEXT_PASS = 3'd5;
  localparam logic [ACT_W-1:0] ACT_EMIT0     = 3'd6;
  localparam logic [ACT_W-1:0] ACT_EMIT1     = 3'd7;

  // jump conditions
  localparam logic [COND_W-1:0] COND_NEVER    = 4'd0;
  localparam logic [COND_W-1:0] COND_ALWAYS   = 4'd1;
  localparam logic [COND_W-1:0] COND_NO_INPUT = 4'd2;
  localparam logic [COND_W-1:0] COND_SMALL    = 4'd3;
  localparam logic [COND_W-1:0] COND_DIV_BUSY = 4'd4;
  localparam logic [COND_W-1:0] COND_D_GT_Q   = 4'd5;
  localparam logic [COND_W-1:0] COND_REM_ZERO = 4'd6;
  localparam logic [COND_W-1:0] COND_PASS0    = 4'd7;
  localparam logic [COND_W-1:0] COND_PASS1    = 4'd8;
  localparam logic [COND_W-1:0] COND_OUT_FULL = 4'd9;

  // program steps
  localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
  localparam logic [STEP_W-1:0] STEP_CHECK     = 4'd1;
  localparam logic [STEP_W-1:0] STEP_DIV_GO    = 4'd2;
  localparam logic [STEP_W-1:0] STEP_DIV_WAIT  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_BOUND     = 4'd4;
  localparam logic [STEP_W-1:0] STEP_REM       = 4'd5;
  localparam logic [STEP_W-1:0] STEP_INC       = 4'd6;
  localparam logic [STEP_W-1:0] STEP_NODIV     = 4'd7;
  localparam logic [STEP_W-1:0] STEP_OUT1      = 4'd8;
  localparam logic [STEP_W-1:0] STEP_OUT1_DONE = 4'd9;
  localparam logic [STEP_W-1:0] STEP_FOUND     = 4'd10;
  localparam logic [STEP_W-1:0] STEP_PASS2     = 4'd11;
  localparam logic [STEP_W-1:0] STEP_OUT0      = 4'd12;
  localparam logic [STEP_W-1:0] STEP_OUT0_DONE = 4'd13;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic tiny;
    logic div_busy;
    logic d_gt_q;
    logic rem_zero;
    logic pass;
    logic out_full;
  } stat_t;

  // Jump to target when cond holds, else fall through to step + 1.
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      STEP_IDLE:      w = '{ACT_LOAD,      COND_NO_INPUT, STEP_IDLE};
      STEP_CHECK:     w = '{ACT_SET_D,     COND_SMALL,    STEP_OUT0};
      STEP_DIV_GO:    w = '{ACT_DIV_GO,    COND_NEVER,    STEP_IDLE};
      STEP_DIV_WAIT:  w = '{ACT_NONE,      COND_DIV_BUSY, STEP_DIV_WAIT};
      STEP_BOUND:     w = '{ACT_NONE,      COND_D_GT_Q,   STEP_NODIV};
      STEP_REM:       w = '{ACT_NONE,      COND_REM_ZERO, STEP_FOUND};
      STEP_INC:       w = '{ACT_D_INC,     COND_ALWAYS,   STEP_DIV_GO};
      STEP_NODIV:     w = '{ACT_NONE,      COND_PASS0,    STEP_OUT0};
      STEP_OUT1:      w = '{ACT_EMIT1,     COND_OUT_FULL, STEP_OUT1};
      STEP_OUT1_DONE: w = '{ACT_NONE,      COND_ALWAYS,   STEP_IDLE};
      STEP_FOUND:     w = '{ACT_NONE,      COND_PASS1,    STEP_OUT0};
      STEP_PASS2:     w = '{ACT_NEXT_PASS, COND_ALWAYS,   STEP_DIV_GO};
      STEP_OUT0:      w = '{ACT_EMIT0,     COND_OUT_FULL, STEP_OUT0};
      STEP_OUT0_DONE: w = '{ACT_NONE,      COND_ALWAYS,   STEP_IDLE};
      default:        w = '{ACT_NONE,      COND_ALWAYS,   STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/spt_if.sv =====
// Handshake channel interfaces for the semiprime tester.
// Depends on spt_pkg for the value width.
interface spt_value_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [spt_pkg::VALUE_WIDTH-1:0] value;
  modport source(output valid, output value, input ready);
  modport sink(input valid, input value, output ready);
endinterface

interface spt_result_if;
  logic valid;
  logic ready;
  logic is_semiprime;
  modport source(output valid, output is_semiprime, input ready);
  modport sink(input valid, input is_semiprime, output ready);
endinterface

// ===== rtl/spt_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on spt_pkg for widths.
module spt_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [spt_pkg::VALUE_WIDTH-1:0] dividend,
  input  logic [spt_pkg::VALUE_WIDTH-1:0] divisor,
  output logic                           busy,
  output logic [spt_pkg::VALUE_WIDTH-1:0] quo,
  output logic [spt_pkg::VALUE_WIDTH-1:0] rem
);

  logic [spt_pkg::CNT_W-1:0]       count;
  logic [spt_pkg::VALUE_WIDTH-1:0] dvs;
  logic [spt_pkg::VALUE_WIDTH:0]   rem_sh;
  logic [spt_pkg::VALUE_WIDTH:0]   diff;

  assign busy   = (count != '0);
  assign rem_sh = {rem, quo[spt_pkg::VALUE_WIDTH-1]};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= spt_pkg::CNT_W'(spt_pkg::VALUE_WIDTH);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[spt_pkg::VALUE_WIDTH]) begin
        rem <= diff[spt_pkg::VALUE_WIDTH-1:0];
        quo <= {quo[spt_pkg::VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem <= rem_sh[spt_pkg::VALUE_WIDTH-1:0];
        quo <= {quo[spt_pkg::VALUE_WIDTH-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/spt_seq.sv =====
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on spt_pkg for the ROM, codes and status struct.
module spt_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  spt_pkg::stat_t             stat,
  output logic [spt_pkg::ACT_W-1:0]  act
);

  logic [spt_pkg::STEP_W-1:0] step;
  logic [spt_pkg::STEP_W-1:0] step_next;
  spt_pkg::uword_t            uw;
  logic                       jump;

  assign uw  = spt_pkg::ucode(step);
  assign act = uw.act;

  always_comb begin
    case (uw.cond)
      spt_pkg::COND_NEVER:    jump = 1'b0;
      spt_pkg::COND_ALWAYS:   jump = 1'b1;
      spt_pkg::COND_NO_INPUT: jump = !stat.in_valid;
      spt_pkg::COND_SMALL:    jump = stat.tiny;
      spt_pkg::COND_DIV_BUSY: jump = stat.div_busy;
      spt_pkg::COND_D_GT_Q:   jump = stat.d_gt_q;
      spt_pkg::COND_REM_ZERO: jump = stat.rem_zero;
      spt_pkg::COND_PASS0:    jump = !stat.pass;
      spt_pkg::COND_PASS1:    jump = stat.pass;
      spt_pkg::COND_OUT_FULL: jump = stat.out_full;
      default:                jump = 1'b1;
    endcase
    step_next = jump ? uw.target : step + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= spt_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== rtl/semiprime_tester.sv =====
// Semiprime tester: answers 1 when a signed value is the product of exactly two primes
// (prime squares included); negative values and values below 4 give 0. One request is
// worked at a time by a microcoded sequencer driving trial division through a one-bit-
// per-cycle divider. Each trial divisor takes issue, divide, bound, remainder and
// increment steps. The first pass tries divisors 2..sqrt(n), the second tries
// p..sqrt(n/p) for the smallest factor p. A small or negative value is answered on a
// short path through the check and emit steps, without division. A finished result
// sits in an output register, so the next request is accepted while it waits. Depends
// on spt_pkg, spt_if, spt_seq and spt_div.
module semiprime_tester (
  input  logic         clk,
  input  logic         rst,
  spt_value_if.sink    operand,
  spt_result_if.source result
);

  logic [spt_pkg::ACT_W-1:0]       act;
  spt_pkg::stat_t                  stat;
  logic [spt_pkg::VALUE_WIDTH-1:0] t;
  logic [spt_pkg::VALUE_WIDTH-1:0] d;
  logic                            pass;
  logic                            res_full;
  logic                            res_flag;
  logic                            div_busy;
  logic [spt_pkg::VALUE_WIDTH-1:0] div_q;
  logic [spt_pkg::VALUE_WIDTH-1:0] div_r;
  logic                            out_blocked;

  spt_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .act  (act)
  );

  spt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (act == spt_pkg::ACT_DIV_GO),
    .dividend (t),
    .divisor  (d),
    .busy     (div_busy),
    .quo      (div_q),
    .rem      (div_r)
  );

  assign out_blocked = res_full && !result.ready;

  always_comb begin
    stat.in_valid = operand.valid;
    // sign bit set, or below 4
    stat.tiny     = t[spt_pkg::VALUE_WIDTH-1] || (t < spt_pkg::VALUE_WIDTH'(4));
    stat.div_busy = div_busy;
    stat.d_gt_q   = (d > div_q);
    stat.rem_zero = (div_r == '0);
    stat.pass     = pass;
    stat.out_full = out_blocked;
  end

  assign operand.ready       = (act == spt_pkg::ACT_LOAD);
  assign result.valid        = res_full;
  assign result.is_semiprime = res_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      pass     <= 1'b0;
      res_full <= 1'b0;
    end else begin
      case (act)
        spt_pkg::ACT_LOAD:      pass <= 1'b0;
        spt_pkg::ACT_NEXT_PASS: pass <= 1'b1;
        default: ;
      endcase
      if (((act == spt_pkg::ACT_EMIT0) || (act == spt_pkg::ACT_EMIT1)) && !out_blocked) begin
        res_full <= 1'b1;
      end else if (res_full && result.ready) begin
        res_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (act)
      spt_pkg::ACT_LOAD: begin
        if (operand.valid) begin
          t <= operand.value;
        end
      end
      spt_pkg::ACT_SET_D:     d <= spt_pkg::VALUE_WIDTH'(2);
      spt_pkg::ACT_D_INC:     d <= d + 1'b1;
      // second pass: test the cofactor starting from the smallest factor
      spt_pkg::ACT_NEXT_PASS: t <= div_q;
      spt_pkg::ACT_EMIT0: begin
        if (!out_blocked) begin
          res_flag <= 1'b0;
        end
      end
      spt_pkg::ACT_EMIT1: begin
        if (!out_blocked) begin
          res_flag <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/spt_check.sv =====
// Port-level assertions for the semiprime tester, bound to the top level.
// Depends on spt_pkg for the value width.
module spt_check (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic signed [spt_pkg::VALUE_WIDTH-1:0] in_value,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic                                  out_flag
);

  logic in_acc;
  logic in_small;

  assign in_acc   = in_valid && in_ready;
  assign in_small = (in_value < spt_pkg::VALUE_WIDTH'(signed'(4)));

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_flag))
    else $error("result changed while stalled");

  // only one request in flight
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("request accepted back to back");

  // small or negative values answer 0 on the short path
  a_small_fast: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_small && !out_valid |-> ##3 (out_valid && !out_flag))
    else $error("small value not answered 0 on time");

  // a new result appears only while no request can be taken
  a_rise_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_ready)
    else $error("result raised while idle");

endmodule

bind semiprime_tester spt_check u_spt_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (operand.valid),
  .in_ready  (operand.ready),
  .in_value  (operand.value),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_flag  (result.is_semiprime)
);
